// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on clk, off while rst_n is low.
`define ASSERT_CLKRST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("%m: assertion failed");

// Concurrent assertion sampled on clk, active during reset as well.
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("%m: assertion failed");

`endif

// ===== rtl/core/sv39_ptw_pkg.sv =====
`default_nettype none

package sv39_ptw_pkg;

  localparam int unsigned TablePages   = 16;
  localparam int unsigned VaLimitBits  = 38;
  localparam int unsigned SlotsPerPage = 512;
  localparam int unsigned StoreDepth   = TablePages * SlotsPerPage;
  localparam int unsigned PageW        = (TablePages > 1) ? $clog2(TablePages) : 1;
  localparam int unsigned AddrW        = PageW + 9;
  localparam int unsigned TopLevel     = 2;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_LARGE = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_NOT_USER  = 3'd3;
  localparam logic [2:0] ST_OUTSIDE   = 3'd4;

  // PTE bit positions
  localparam int unsigned PteValidBit = 0;
  localparam int unsigned PteUserBit  = 4;

  typedef struct packed {
    logic             done;
    logic [2:0]       status;
    logic [PageW-1:0] next_page;
    logic [55:0]      phys_addr;
  } step_t;

endpackage

`default_nettype wire

// ===== rtl/core/sv39_page_table_walker.sv =====
// Sv39 page table walker with an on-block table store of 16 pages x 512
// 64-bit entries. After reset the store is swept to zero, one entry per
// cycle; s_axis_tready stays low during the sweep (root_page writes are
// taken). A transaction with tuser 0 writes one entry and produces its
// result in the cycle after acceptance. A translation (tuser 1) passes,
// for each level visited, through a store read state and then an entry
// check state; an address-too-large or root-outside result is produced
// straight from acceptance without a walk. The result sits in an output
// register; the next transaction is accepted once the walker is idle and
// that register is empty or being drained.
`default_nettype none

module sv39_page_table_walker (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration
  input  logic         cfg_we_i,
  input  logic [3:0]   cfg_wdata_i,     // root_page
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [119:0] s_axis_tdata,    // virt_addr[38:0], entry_index[51:39],
                                        // entry_data[115:52], zero pad
  input  logic         s_axis_tuser,    // func
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata     // status[2:0], phys_addr[58:3], zero pad
);

  localparam int unsigned AddrW = sv39_ptw_pkg::AddrW;
  localparam int unsigned PageW = sv39_ptw_pkg::PageW;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_CHECK = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;
  logic [3:0]       root_q;

  logic             out_valid_q, out_valid_d;
  logic [2:0]       out_status_q, out_status_d;
  logic [55:0]      out_pa_q, out_pa_d;

  logic [38:0]      va_q, va_d;
  logic [PageW-1:0] page_q, page_d;
  logic [1:0]       level_q, level_d;

  logic [63:0]      store [sv39_ptw_pkg::StoreDepth];
  logic [63:0]      rdata_q;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [63:0]      mem_wdata;
  logic [AddrW-1:0] mem_raddr;
  logic [8:0]       slot;

  logic [38:0]      in_va;
  logic [12:0]      in_idx;
  logic [63:0]      in_data;
  logic             in_acc;
  logic             idx_in_store;

  sv39_ptw_pkg::step_t step;

  assign in_va   = s_axis_tdata[38:0];
  assign in_idx  = s_axis_tdata[51:39];
  assign in_data = s_axis_tdata[115:52];

  assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign idx_in_store  = 32'(in_idx) < sv39_ptw_pkg::StoreDepth;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_pa_q, out_status_q};

  always_comb begin
    unique case (level_q)
      2'd2:    slot = va_q[38:30];
      2'd1:    slot = va_q[29:21];
      default: slot = va_q[20:12];
    endcase
  end

  assign mem_raddr = {page_q, slot};
  assign mem_we    = (state_q == S_CLEAR) || (in_acc && !s_axis_tuser && idx_in_store);
  assign mem_waddr = (state_q == S_CLEAR) ? clr_cnt_q : AddrW'(in_idx);
  assign mem_wdata = (state_q == S_CLEAR) ? 64'd0 : in_data;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    rdata_q <= store[mem_raddr];
  end

  sv39_ptw_step u_step (
    .pte_i   (rdata_q),
    .level_i (level_q),
    .step_o  (step)
  );

  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_pa_d     = out_pa_q;
    va_d         = va_q;
    page_d       = page_q;
    level_d      = level_q;
    unique case (state_q)
      S_CLEAR: begin
        clr_cnt_d = clr_cnt_q + AddrW'(1);
        if (32'(clr_cnt_q) == sv39_ptw_pkg::StoreDepth - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          va_d     = in_va;
          page_d   = PageW'(root_q);
          level_d  = 2'(sv39_ptw_pkg::TopLevel);
          out_pa_d = '0;
          priority if (!s_axis_tuser) begin
            out_valid_d  = 1'b1;
            out_status_d = sv39_ptw_pkg::ST_OK;
          end else if ((in_va >> sv39_ptw_pkg::VaLimitBits) != '0) begin
            out_valid_d  = 1'b1;
            out_status_d = sv39_ptw_pkg::ST_TOO_LARGE;
          end else if (32'(root_q) >= sv39_ptw_pkg::TablePages) begin
            out_valid_d  = 1'b1;
            out_status_d = sv39_ptw_pkg::ST_OUTSIDE;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (step.done) begin
          out_valid_d  = 1'b1;
          out_status_d = step.status;
          out_pa_d     = step.phys_addr;
          state_d      = S_IDLE;
        end else begin
          // descend one level
          page_d  = step.next_page;
          level_d = level_q - 2'd1;
          state_d = S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      root_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        root_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_pa_q     <= out_pa_d;
    va_q         <= va_d;
    page_q       <= page_d;
    level_q      <= level_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/sv39_ptw_step.sv =====
`default_nettype none

// Evaluate one fetched entry: follow it as a pointer, finish with a
// physical address, or stop with an error status.
module sv39_ptw_step (
  input  logic [63:0]         pte_i,
  input  logic [1:0]          level_i,
  output sv39_ptw_pkg::step_t step_o
);

  logic [43:0] ppn;

  assign ppn = pte_i[53:10];

  always_comb begin
    step_o.done      = 1'b1;
    step_o.status    = sv39_ptw_pkg::ST_OK;
    step_o.next_page = ppn[sv39_ptw_pkg::PageW-1:0];
    step_o.phys_addr = '0;
    if (!pte_i[sv39_ptw_pkg::PteValidBit]) begin
      step_o.status = sv39_ptw_pkg::ST_INVALID;
    end else if (level_i != 2'd0) begin
      if (ppn >= 44'(sv39_ptw_pkg::TablePages)) begin
        step_o.status = sv39_ptw_pkg::ST_OUTSIDE;
      end else begin
        step_o.done = 1'b0;
      end
    end else if (!pte_i[sv39_ptw_pkg::PteUserBit]) begin
      step_o.status = sv39_ptw_pkg::ST_NOT_USER;
    end else begin
      step_o.phys_addr = {ppn, 12'b0};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sv39_ptw_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module sv39_ptw_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [119:0] s_axis_tdata,
  input logic         s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [63:0]  m_axis_tdata
);

  logic in_acc;
  logic va_large;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign va_large = (s_axis_tdata[38:0] >> sv39_ptw_pkg::VaLimitBits) != '0;

  // A stalled result holds
  `ASSERT_CLKRST(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

  // A new transaction is only taken when the result register can drain
  `ASSERT_CLKRST(a_in_no_overrun, clk_i, rst_ni,
    s_axis_tready && m_axis_tvalid |-> m_axis_tready)

  // Entry writes give a clean ok result in the cycle after acceptance
  `ASSERT_CLKRST(a_write_done, clk_i, rst_ni,
    in_acc && !s_axis_tuser |=> m_axis_tvalid && m_axis_tdata[2:0] == sv39_ptw_pkg::ST_OK
      && m_axis_tdata[58:3] == '0)

  // Oversized addresses are rejected without a walk
  `ASSERT_CLKRST(a_too_large, clk_i, rst_ni,
    in_acc && s_axis_tuser && va_large |=> m_axis_tvalid
      && m_axis_tdata[2:0] == sv39_ptw_pkg::ST_TOO_LARGE)

  // Any error result carries a zero address
  `ASSERT_CLKRST(a_err_zero_pa, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tdata[2:0] != sv39_ptw_pkg::ST_OK |-> m_axis_tdata[58:3] == '0)

endmodule

bind sv39_page_table_walker sv39_ptw_checker u_sv39_ptw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

module testbench;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_XLAT  = 1'b1;

  localparam logic [9:0] PTE_V   = 10'h001;
  localparam logic [9:0] PTE_RWX = 10'h00e;
  localparam logic [9:0] PTE_U   = 10'h010;

  localparam int WATCHDOG_LIMIT = 50000;
  localparam int DRAIN_TAIL     = 16;
  localparam int PHASE_ITEMS    = 220;

  typedef struct packed {
    logic [2:0]  status;
    logic [55:0] phys_addr;
  } xlat_res_t;

  logic         clk_i;
  logic         rst_ni        = 1'b0;
  logic         cfg_we_i      = 1'b0;
  logic [3:0]   cfg_wdata_i   = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata  = '0;  // virt_addr, entry_index, entry_data, zero pad
  logic         s_axis_tuser  = 1'b0; // func
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;         // status, phys_addr, zero pad

  // Walker shadow: table contents and root page as the block should hold them
  logic [63:0] pt_shadow [sv39_ptw_pkg::StoreDepth];
  logic [3:0]  root_shadow;

  xlat_res_t   pending_results [$];
  logic [38:0] mapped_vas [$];
  xlat_res_t   head_res;
  int          fail_count   = 0;
  int          items_sent   = 0;
  int          quiet_cycles = 0;
  int          src_idle_pct = 0;
  int          snk_stall_pct = 0;

  sv39_page_table_walker u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] mk_pte(logic [43:0] ppn, logic [9:0] flags);
    return {10'b0, ppn, flags};
  endfunction

  function automatic logic [38:0] mk_va(logic [8:0] vpn2, logic [8:0] vpn1,
                                        logic [8:0] vpn0, logic [11:0] offs);
    return {vpn2, vpn1, vpn0, offs};
  endfunction

  // Apply one transaction to the shadow and return the result it must produce
  function automatic xlat_res_t walk_outcome(logic func, logic [38:0] va,
                                             logic [12:0] idx, logic [63:0] data);
    xlat_res_t   res;
    logic [43:0] page;
    logic [63:0] pte;
    logic [38:0] shifted;
    logic [8:0]  vpn;
    res.status    = sv39_ptw_pkg::ST_OK;
    res.phys_addr = '0;
    if (func == FUNC_WRITE) begin
      if (idx < sv39_ptw_pkg::StoreDepth) pt_shadow[idx] = data;
      return res;
    end
    if ({1'b0, va} >= (40'd1 << sv39_ptw_pkg::VaLimitBits)) begin
      res.status = sv39_ptw_pkg::ST_TOO_LARGE;
      return res;
    end
    page = 44'(root_shadow);
    if (page >= sv39_ptw_pkg::TablePages) begin
      res.status = sv39_ptw_pkg::ST_OUTSIDE;
      return res;
    end
    for (int lvl = sv39_ptw_pkg::TopLevel; lvl >= 0; lvl--) begin
      shifted = va >> (12 + 9 * lvl);
      vpn     = shifted[8:0];
      pte     = pt_shadow[{page[sv39_ptw_pkg::PageW-1:0], vpn}];
      if (!pte[sv39_ptw_pkg::PteValidBit]) begin
        res.status = sv39_ptw_pkg::ST_INVALID;
        return res;
      end
      if (lvl == 0) begin
        if (!pte[sv39_ptw_pkg::PteUserBit]) begin
          res.status = sv39_ptw_pkg::ST_NOT_USER;
          return res;
        end
        res.phys_addr = {pte[53:10], 12'h000};
      end else begin
        // follow any valid entry as a pointer, whatever its RWX bits
        page = pte[53:10];
        if (page >= sv39_ptw_pkg::TablePages) begin
          res.status = sv39_ptw_pkg::ST_OUTSIDE;
          return res;
        end
      end
    end
    return res;
  endfunction

  task automatic send_item(logic func, logic [38:0] va, logic [12:0] idx,
                           logic [63:0] data);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {4'b0, data, idx, va};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(walk_outcome(func, va, idx, data));
    items_sent++;
  endtask

  task automatic write_pte(logic [12:0] idx, logic [63:0] data);
    logic [63:0] r;
    r = rand64();
    send_item(FUNC_WRITE, r[38:0], idx, data);
  endtask

  task automatic translate_va(logic [38:0] va);
    logic [63:0] r;
    r = rand64();
    send_item(FUNC_XLAT, va, r[12:0], rand64());
  endtask

  // Drop valid and hold until every pending result has come back
  task automatic hold_off();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_root(logic [3:0] pg);
    hold_off();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= pg;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    root_shadow = pg;
  endtask

  function automatic logic [43:0] pick_page();
    logic [63:0] r;
    r = rand64();
    if ($urandom_range(19) == 0) return r[43:0] | 44'h10;
    return 44'(r[3:0]);
  endfunction

  task automatic test_directed_walks();
    set_root(4'd0);
    translate_va('0);
    translate_va(39'h40_0000_0000);
    translate_va('1);
    // full walk to the largest user address, leaf with every bit set
    write_pte({4'd0, 9'h0ff}, mk_pte(44'd1, PTE_V));
    write_pte({4'd1, 9'h1ff}, mk_pte(44'd2, PTE_V));
    write_pte({4'd2, 9'h1ff}, '1);
    translate_va(39'h3f_ffff_ffff);
    write_pte({4'd2, 9'h000}, mk_pte(44'd0, PTE_V));
    translate_va(mk_va(9'h0ff, 9'h1ff, 9'h000, 12'h000));
    write_pte({4'd2, 9'h001}, mk_pte(44'd5, PTE_U));
    translate_va(mk_va(9'h0ff, 9'h1ff, 9'h001, 12'hfff));
    write_pte({4'd1, 9'h000}, mk_pte(44'd16, PTE_V | PTE_RWX));
    translate_va(mk_va(9'h0ff, 9'h000, 9'h000, 12'h123));
    write_pte({4'd0, 9'h001}, mk_pte('1, PTE_V));
    translate_va(mk_va(9'h001, 9'h000, 9'h000, 12'h000));
    write_pte({4'd1, 9'h001}, '0);
    translate_va(mk_va(9'h0ff, 9'h001, 9'h000, 12'h000));
    write_pte(13'h1fff, '1);
    write_pte(13'h0000, '0);
    translate_va('0);
  endtask

  task automatic test_root_extremes();
    set_root(4'd15);
    translate_va(39'h3f_ffff_ffff);
    write_pte({4'd15, 9'h0ff}, mk_pte(44'd1, PTE_V | PTE_RWX));
    translate_va(39'h3f_ffff_ffff);
    set_root(4'd0);
    translate_va(39'h3f_ffff_ffff);
  endtask

  task automatic random_walks(int count);
    logic [63:0] r;
    logic [63:0] hi;
    logic [8:0]  vpn2;
    logic [8:0]  vpn1;
    logic [8:0]  vpn0;
    logic [43:0] p1;
    logic [43:0] p2;
    logic [9:0]  fl;
    logic [38:0] va;
    int          target;
    int          pick;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        // build a three-level mapping with random content, then walk it
        r    = rand64();
        vpn2 = {($urandom_range(9) == 0), r[7:0]};
        vpn1 = r[16:8];
        vpn0 = r[25:17];
        va   = mk_va(vpn2, vpn1, vpn0, r[37:26]);
        p1   = pick_page();
        p2   = pick_page();
        hi   = rand64();
        fl   = hi[9:0];
        fl[sv39_ptw_pkg::PteValidBit] = ($urandom_range(19) != 0);
        write_pte({root_shadow, vpn2}, {hi[63:54], p1, fl});
        hi   = rand64();
        fl   = hi[9:0];
        fl[sv39_ptw_pkg::PteValidBit] = ($urandom_range(19) != 0);
        write_pte({p1[3:0], vpn1}, {hi[63:54], p2, fl});
        hi   = rand64();
        fl   = hi[9:0];
        fl[sv39_ptw_pkg::PteValidBit] = ($urandom_range(9) != 0);
        fl[sv39_ptw_pkg::PteUserBit]  = ($urandom_range(9) != 0);
        write_pte({p2[3:0], vpn0}, {hi[63:10], fl});
        translate_va(va);
        if ($urandom_range(1) == 0) begin
          r = rand64();
          translate_va({va[38:12], r[11:0]});
        end
        mapped_vas.push_back(va);
        if (mapped_vas.size() > 32) void'(mapped_vas.pop_front());
      end else if (pick < 75 || mapped_vas.size() == 0) begin
        r = rand64();
        translate_va(r[38:0]);
      end else if (pick < 88) begin
        r = rand64();
        va = mapped_vas[$urandom_range(mapped_vas.size() - 1)];
        translate_va({va[38:12], r[11:0]});
      end else begin
        r = rand64();
        write_pte(r[12:0], rand64());
      end
      if ($urandom_range(99) < 2) hold_off();
    end
  endtask

  task automatic test_random_no_idle();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    random_walks(PHASE_ITEMS);
  endtask

  task automatic test_random_sender_gaps();
    set_root(4'd15);
    src_idle_pct  = 57;
    snk_stall_pct = 0;
    random_walks(PHASE_ITEMS);
  endtask

  task automatic test_random_receiver_stall();
    set_root(4'($urandom_range(15)));
    src_idle_pct  = 0;
    snk_stall_pct = 57;
    random_walks(PHASE_ITEMS);
  endtask

  task automatic test_random_both_idle();
    set_root(4'($urandom_range(15)));
    src_idle_pct  = 23;
    snk_stall_pct = 23;
    random_walks(PHASE_ITEMS);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no pending transaction: tdata %h", m_axis_tdata);
        fail_count++;
      end else begin
        head_res = pending_results.pop_front();
        if (m_axis_tdata[2:0] !== head_res.status) begin
          $error("status mismatch: expected %0d, actual %0d",
                 head_res.status, m_axis_tdata[2:0]);
          fail_count++;
        end
        if (m_axis_tdata[58:3] !== head_res.phys_addr) begin
          $error("phys_addr mismatch: expected %h, actual %h",
                 head_res.phys_addr, m_axis_tdata[58:3]);
          fail_count++;
        end
      end
    end
  end

  // Count cycles with no transaction on either side; fail once the count reaches WATCHDOG_LIMIT
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** sv39_page_table_walker: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (pt_shadow[i]) pt_shadow[i] = '0;
    root_shadow = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_walks();
    test_root_extremes();
    test_random_no_idle();
    test_random_sender_gaps();
    test_random_receiver_stall();
    test_random_both_idle();

    hold_off();
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("** sv39_page_table_walker: PASSED **");
    end else begin
      $display("** sv39_page_table_walker: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl/core
rtl/core/sv39_ptw_pkg.sv
rtl/core/sv39_ptw_step.sv
rtl/core/sv39_page_table_walker.sv
rtl/core/sv39_ptw_checker.sv
sim/testbench.sv
